// File: sv/fractional_baud_divisor_search_assert.svh
// Assertion macros shared by the baud divisor search RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef FRACTIONAL_BAUD_DIVISOR_SEARCH_ASSERT_SVH
`define FRACTIONAL_BAUD_DIVISOR_SEARCH_ASSERT_SVH

// Check sampled on the rising clock, skipped while reset is asserted.
`define FBDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");

// Check sampled on the rising clock, also during reset.
`define FBDS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`endif

// File: sv/fbds_pkg.sv
// Types and constants of the fractional baud divisor search.
// No dependencies; used by every module of the block.
package fbds_pkg;

  localparam int unsigned NUM_W = 59;  // widest dividend: (pclk << 28) * m
  localparam int unsigned DEN_W = 29;  // widest divisor: baud * (m + d)
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  localparam logic [3:0]  MAX_MULTIPLIER = 4'd15;
  localparam logic [27:0] MAX_DIVISOR    = 28'd65536;

  localparam logic [31:0] ERR_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] HALF_FRAC = 32'h8000_0000;

  // configuration register indexes
  localparam logic REG_CORE_CLOCK  = 1'b0;
  localparam logic REG_ACCEPT_ERR  = 1'b1;

  typedef enum logic [1:0] {
    OP_CAND = 2'd0,
    OP_ACH  = 2'd1,
    OP_PCT  = 2'd2
  } op_sel_e;

  typedef struct packed {
    logic    init;
    logic    div_start;
    op_sel_e op;
    logic    eval;
    logic    ach_store;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic baud_zero;
    logic cand_last;
    logic zero_hit;
    logic found;
  } status_t;

endpackage

// File: sv/fractional_baud_divisor_search.sv
// Top level of the fractional baud divisor search.
// Depends on fbds_pkg, fbds_ctrl, fbds_datapath (and fbds_divider below it).
//
//  channel   ports                                    transfer
//  --------  ---------------------------------------  ---------------------------
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i          edge with cfg_we_i high
//  request   start, busy, baud_rate_i                  edge with start & !busy
//  result    result_valid_o, ok_o, divisor_latch_o,    one-cycle strobe, no stall
//            mul_val_o, div_add_val_o,
//            achieved_baud_o, error_percent_o
//
// Each candidate takes one division on the 59-step bit-serial divider that all
// divisions share. Up to 120 candidates are tried, then, if a divisor was found,
// one division each for the achieved baud and the percent error; the search
// ends early on a zero-error hit, and a zero baud skips the divisions entirely.
// Reset loads core_clock_hz = 100000000 and accepted_error_percent = 3.
// The result strobe lasts one cycle; the next request may be taken in that cycle.
module fractional_baud_divisor_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [28:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] baud_rate_i,
  output logic        result_valid_o,
  output logic        ok_o,
  output logic [16:0] divisor_latch_o,
  output logic [3:0]  mul_val_o,
  output logic [3:0]  div_add_val_o,
  output logic [23:0] achieved_baud_o,
  output logic [7:0]  error_percent_o
);

  fbds_pkg::cmd_t    cmd;
  fbds_pkg::status_t st;

  fbds_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .st_i           (st),
    .cmd_o          (cmd)
  );

  fbds_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .baud_rate_i     (baud_rate_i),
    .cmd_i           (cmd),
    .st_o            (st),
    .ok_o            (ok_o),
    .divisor_latch_o (divisor_latch_o),
    .mul_val_o       (mul_val_o),
    .div_add_val_o   (div_add_val_o),
    .achieved_baud_o (achieved_baud_o),
    .error_percent_o (error_percent_o)
  );

endmodule

// File: sv/fbds_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on fbds_pkg for operand widths.
module fbds_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fbds_pkg::NUM_W-1:0] num_i,
  input  logic [fbds_pkg::DEN_W-1:0] den_i,
  output logic                       busy_o,
  output logic [fbds_pkg::NUM_W-1:0] quo_o
);

  logic [fbds_pkg::DEN_W-1:0] rem_q, rem_d;
  logic [fbds_pkg::DEN_W-1:0] den_q, den_d;
  logic [fbds_pkg::NUM_W-1:0] quo_q, quo_d;
  logic [fbds_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [fbds_pkg::DEN_W:0]   trial;
  logic                       ge;

  // dividend bits leave quo_q at the top while quotient bits enter at the bottom
  assign trial = {rem_q, quo_q[fbds_pkg::NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      den_d = den_i;
      quo_d = num_i;
      cnt_d = fbds_pkg::CNT_W'(fbds_pkg::NUM_W);
    end else if (cnt_q != '0) begin
      rem_d = ge ? fbds_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[fbds_pkg::DEN_W-1:0];
      quo_d = {quo_q[fbds_pkg::NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

endmodule

// File: sv/fbds_datapath.sv
// Datapath: config registers, candidate counters, best tracking, result registers.
// Depends on fbds_pkg, fbds_divider and the assertion macro header.
`include "fractional_baud_divisor_search_assert.svh"

module fbds_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [28:0]      cfg_wdata_i,
  input  logic [23:0]      baud_rate_i,
  input  fbds_pkg::cmd_t   cmd_i,
  output fbds_pkg::status_t st_o,
  output logic             ok_o,
  output logic [16:0]      divisor_latch_o,
  output logic [3:0]       mul_val_o,
  output logic [3:0]       div_add_val_o,
  output logic [23:0]      achieved_baud_o,
  output logic [7:0]       error_percent_o
);

  logic [28:0] core_clk_q;
  logic [6:0]  accept_q;
  logic [23:0] baud_q;
  logic [3:0]  m_q, d_q;
  logic [31:0] best_err_q;
  logic [16:0] best_dl_q;
  logic [3:0]  best_m_q, best_d_q;
  logic [26:0] ach_q;

  logic        ok_q;
  logic [16:0] dl_out_q;
  logic [3:0]  m_out_q, d_out_q;
  logic [23:0] ach_out_q;
  logic [7:0]  pct_out_q;

  logic [26:0]                pclk;
  logic [4:0]                 cand_sum, best_sum;
  logic [30:0]                cand_prod;
  logic [28:0]                cand_den;
  logic [26:0]                ach_num;
  logic [21:0]                ach_den;
  logic [26:0]                diff;
  logic [33:0]                pct_num;
  logic [fbds_pkg::NUM_W-1:0] div_num;
  logic [fbds_pkg::DEN_W-1:0] div_den;
  logic                       div_busy;
  logic [fbds_pkg::NUM_W-1:0] quo;

  logic [31:0] frac, err;
  logic        round_up;
  logic [27:0] dl;
  logic        in_range, better, cand_last, found;
  logic [fbds_pkg::NUM_W-1:0] pct;
  logic        pct_ok, accept_res;
  logic [7:0]  pct_sat;

  assign pclk     = core_clk_q[28:2];
  assign cand_sum = {1'b0, m_q} + {1'b0, d_q};
  assign best_sum = {1'b0, best_m_q} + {1'b0, best_d_q};

  assign cand_prod = 31'(pclk) * 31'(m_q);
  assign cand_den  = 29'(baud_q) * 29'(cand_sum);
  assign ach_num   = 27'(pclk[26:4]) * 27'(best_m_q);
  assign ach_den   = 22'(best_dl_q) * 22'(best_sum);
  assign diff      = ({3'b0, baud_q} > ach_q) ? ({3'b0, baud_q} - ach_q)
                                              : (ach_q - {3'b0, baud_q});
  assign pct_num   = 34'(diff) * 34'd100;

  always_comb begin
    case (cmd_i.op)
      fbds_pkg::OP_CAND: begin
        div_num = {cand_prod, 28'b0};
        div_den = cand_den;
      end
      fbds_pkg::OP_ACH: begin
        div_num = fbds_pkg::NUM_W'(ach_num);
        div_den = fbds_pkg::DEN_W'(ach_den);
      end
      fbds_pkg::OP_PCT: begin
        div_num = fbds_pkg::NUM_W'(pct_num);
        div_den = fbds_pkg::DEN_W'(baud_q);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  fbds_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // 27.32 quotient: round to nearest, exact half stays down
  assign frac      = quo[31:0];
  assign round_up  = frac > fbds_pkg::HALF_FRAC;
  assign err       = round_up ? (~frac + 32'd1) : frac;
  assign dl        = quo[fbds_pkg::NUM_W-1:32] + 28'(round_up);
  assign in_range  = (dl != '0) && (dl <= fbds_pkg::MAX_DIVISOR);
  assign better    = in_range && (err < best_err_q);
  assign cand_last = (m_q == fbds_pkg::MAX_MULTIPLIER) && (d_q == m_q - 4'd1);
  assign found     = best_dl_q != '0;
  assign pct       = quo;
  assign pct_ok    = pct < fbds_pkg::NUM_W'(accept_q);
  assign accept_res = found && pct_ok;
  assign pct_sat   = (pct > fbds_pkg::NUM_W'(255)) ? 8'd255 : pct[7:0];

  assign st_o.div_busy  = div_busy;
  assign st_o.baud_zero = baud_q == '0;
  assign st_o.cand_last = cand_last;
  assign st_o.zero_hit  = better && (err == '0);
  assign st_o.found     = found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_clk_q <= 29'd100000000;
      accept_q   <= 7'd3;
      m_q        <= 4'd1;
      d_q        <= '0;
      best_dl_q  <= '0;
      best_err_q <= fbds_pkg::ERR_INIT;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fbds_pkg::REG_CORE_CLOCK: core_clk_q <= cfg_wdata_i;
          fbds_pkg::REG_ACCEPT_ERR: accept_q   <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.init) begin
        m_q        <= 4'd1;
        d_q        <= '0;
        best_dl_q  <= '0;
        best_err_q <= fbds_pkg::ERR_INIT;
      end else if (cmd_i.eval) begin
        if (better) begin
          best_err_q <= err;
          best_dl_q  <= dl[16:0];
        end
        if (!cand_last) begin
          if (d_q == m_q - 4'd1) begin
            m_q <= m_q + 4'd1;
            d_q <= '0;
          end else begin
            d_q <= d_q + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      baud_q   <= baud_rate_i;
      best_m_q <= '0;
      best_d_q <= '0;
    end else if (cmd_i.eval && better) begin
      best_m_q <= m_q;
      best_d_q <= d_q;
    end
    if (cmd_i.ach_store) begin
      ach_q <= quo[26:0];
    end
    if (cmd_i.finish) begin
      ok_q      <= accept_res;
      dl_out_q  <= accept_res ? best_dl_q : '0;
      m_out_q   <= accept_res ? best_m_q : '0;
      d_out_q   <= accept_res ? best_d_q : '0;
      ach_out_q <= found ? ach_q[23:0] : '0;
      pct_out_q <= found ? pct_sat : '0;
    end
  end

  assign ok_o            = ok_q;
  assign divisor_latch_o = dl_out_q;
  assign mul_val_o       = m_out_q;
  assign div_add_val_o   = d_out_q;
  assign achieved_baud_o = ach_out_q;
  assign error_percent_o = pct_out_q;

  `FBDS_ASSERT(a_cand_order, clk_i, rst_ni, (m_q != '0) && (d_q < m_q))
  `FBDS_ASSERT(a_best_dl_range, clk_i, rst_ni, 28'(best_dl_q) <= fbds_pkg::MAX_DIVISOR)

endmodule

// File: sv/fbds_ctrl.sv
// Controller FSM: sequences the candidate search and the two final divisions.
// Depends on fbds_pkg and the assertion macro header.
`include "fractional_baud_divisor_search_assert.svh"

module fbds_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              result_valid_o,
  input  fbds_pkg::status_t st_i,
  output fbds_pkg::cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_C_RUN  = 8'b0000_0010,
    S_C_WAIT = 8'b0000_0100,
    S_A_RUN  = 8'b0000_1000,
    S_A_WAIT = 8'b0001_0000,
    S_P_RUN  = 8'b0010_0000,
    S_P_WAIT = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    cmd_o   = '0;
    cmd_o.op = fbds_pkg::OP_CAND;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.init = 1'b1;
          state_d    = S_C_RUN;
        end
      end
      S_C_RUN: begin
        if (st_i.baud_zero) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_C_WAIT;
        end
      end
      S_C_WAIT: begin
        if (!st_i.div_busy) begin
          cmd_o.eval = 1'b1;
          state_d    = (st_i.zero_hit || st_i.cand_last) ? S_A_RUN : S_C_RUN;
        end
      end
      S_A_RUN: begin
        if (!st_i.found) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.op        = fbds_pkg::OP_ACH;
          cmd_o.div_start = 1'b1;
          state_d         = S_A_WAIT;
        end
      end
      S_A_WAIT: begin
        if (!st_i.div_busy) begin
          cmd_o.ach_store = 1'b1;
          state_d         = S_P_RUN;
        end
      end
      S_P_RUN: begin
        cmd_o.op        = fbds_pkg::OP_PCT;
        cmd_o.div_start = 1'b1;
        state_d         = S_P_WAIT;
      end
      S_P_WAIT: begin
        if (!st_i.div_busy) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        valid_d      = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = valid_q;

  `FBDS_ASSERT(a_strobe_idle, clk_i, rst_ni, valid_q |-> (state_q == S_IDLE))
  `FBDS_ASSERT(a_no_restart, clk_i, rst_ni, cmd_o.div_start |-> !st_i.div_busy)
  `FBDS_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)

endmodule
